// ----- rtl/qrbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// QR bit stream packer package
// Shared types and constants for the QR bit stream packer.
// ----------------------------------------------------------------------------
package qrbsp_pkg;

  // Item kinds on the request channel.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_PAD   = 1'b1;

  // Alternating pad codewords, first one first.
  localparam logic [7:0] PAD_BYTE_A = 8'hEC;
  localparam logic [7:0] PAD_BYTE_B = 8'h11;

  // Held partial byte: up to seven bits and their count.
  localparam int unsigned HELD_W  = 7;
  localparam int unsigned HCNT_W  = 3;
  // Pad byte counter width: up to 63 pad bytes per request.
  localparam int unsigned PADC_W  = 6;

  typedef logic [HELD_W-1:0] held_t;
  typedef logic [HCNT_W-1:0] hcnt_t;
  typedef logic [PADC_W-1:0] padc_t;

  // Sequencer phases.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_PADS
  } state_e;

endpackage

// ----- rtl/qr_bit_stream_packer_top.sv -----
// A byte is registered at the output at the end of the cycle whose bit run completes it; an
// accepted request is first loaded into the field shift register and sequencer state.
// The request channel is stalled whenever the sequencer is not idle, and an output stall
// holds the sequencer. The byte-wide digit path moves at most one byte boundary per cycle
// while the output is not stalled; pad bytes leave at one per cycle while the output is
// not stalled. Reset clears the held bits, sequencer and output valid.
// ----------------------------------------------------------------------------
// QR bit stream packer
// Packs write fields and terminator/pad sequences into an MSB-first byte
// stream, one byte-wide digit per unstalled cycle through a field shift register.
// ----------------------------------------------------------------------------
module qr_bit_stream_packer_top #(
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  num_bits_i,
  input  logic [8:0]  pad_bits_i,
  // Byte channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FIELD_BITS + 1);

  // State.
  qrbsp_pkg::state_e             state_q, state_d;
  logic [MAX_FIELD_BITS-1:0]     sh_q, sh_d;
  logic [CNT_W-1:0]              rem_q, rem_d;
  qrbsp_pkg::held_t              held_q, held_d;
  qrbsp_pkg::hcnt_t              hcnt_q, hcnt_d;
  qrbsp_pkg::padc_t              padc_q, padc_d;
  logic                          psel_q, psel_d;
  logic                          ovld_q, ovld_d;
  logic [7:0]                    obyte_q, obyte_d;
  logic                          olast_q, olast_d;

  // Request decode.
  logic                          in_acc;
  logic                          advance;
  logic [MAX_FIELD_BITS+31:0]    val_wide;
  logic [MAX_FIELD_BITS-1:0]     val_fit;
  logic [CNT_W-1:0]              wr_n;
  logic [8:0]                    pad_rest;
  logic [2:0]                    pad_fill;
  logic [8:0]                    pad_left;

  // Digit path.
  logic [3:0]                    room;
  logic                          full;
  logic [3:0]                    k;
  logic [7:0]                    top8;
  logic [14:0]                   comb_full;
  logic [14:0]                   comb_part;
  logic [CNT_W-1:0]              rem_after;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign advance = !ovld_q || !out_stall_i;

  assign val_wide = {{MAX_FIELD_BITS{1'b0}}, value_i};
  assign val_fit  = val_wide[MAX_FIELD_BITS-1:0];

  // Saturate the field length to the widest supported field.
  assign wr_n = ({1'b0, num_bits_i} > 7'(MAX_FIELD_BITS)) ?
                CNT_W'(MAX_FIELD_BITS) : CNT_W'(num_bits_i);

  // Terminator plus fill to the byte boundary, then whole pad bytes.
  assign pad_rest = pad_bits_i - 9'd4;
  assign pad_fill = 3'd4 - hcnt_q;
  assign pad_left = pad_rest - {6'b0, pad_fill};

  // One digit: complete the held byte if enough bits remain, else absorb all.
  assign room      = 4'd8 - {1'b0, hcnt_q};
  assign full      = (rem_q >= CNT_W'(room));
  assign k         = full ? room : rem_q[3:0];
  assign top8      = sh_q[MAX_FIELD_BITS-1 -: 8];
  assign comb_full = {held_q, top8} >> hcnt_q;
  assign comb_part = ({8'b0, held_q} << k) | {7'b0, top8 >> (4'd8 - k)};
  assign rem_after = rem_q - CNT_W'(k);

  // Sequencer next state and datapath updates.
  always_comb begin
    state_d = state_q;
    sh_d    = sh_q;
    rem_d   = rem_q;
    held_d  = held_q;
    hcnt_d  = hcnt_q;
    padc_d  = padc_q;
    psel_d  = psel_q;
    ovld_d  = ovld_q && out_stall_i;
    obyte_d = obyte_q;
    olast_d = olast_q;

    unique case (state_q)
      qrbsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          psel_d = 1'b0;
          if (kind_i == qrbsp_pkg::KIND_WRITE) begin
            rem_d   = wr_n;
            sh_d    = val_fit << (CNT_W'(MAX_FIELD_BITS) - wr_n);
            padc_d  = '0;
            state_d = qrbsp_pkg::ST_BITS;
          end else begin
            sh_d = '0;
            if (pad_bits_i <= 9'd4) begin
              rem_d  = CNT_W'(pad_bits_i[2:0]);
              padc_d = '0;
            end else begin
              rem_d  = CNT_W'(4'd4 + {1'b0, pad_fill});
              padc_d = (pad_rest >= {6'b0, pad_fill}) ? pad_left[8:3] : '0;
            end
            state_d = qrbsp_pkg::ST_BITS;
          end
        end
      end

      qrbsp_pkg::ST_BITS: begin
        if (advance) begin
          sh_d  = sh_q << k;
          rem_d = rem_after;
          if (full) begin
            ovld_d  = 1'b1;
            obyte_d = comb_full[7:0];
            olast_d = (rem_after < CNT_W'(8)) && (padc_q == '0);
            held_d  = '0;
            hcnt_d  = '0;
          end else begin
            held_d = comb_part[6:0];
            hcnt_d = hcnt_q + k[2:0];
          end
          if (rem_after == '0 || (!full && rem_after == '0)) begin
            state_d = (padc_q != '0) ? qrbsp_pkg::ST_PADS : qrbsp_pkg::ST_IDLE;
          end
        end
      end

      qrbsp_pkg::ST_PADS: begin
        if (advance) begin
          ovld_d  = 1'b1;
          obyte_d = psel_q ? qrbsp_pkg::PAD_BYTE_B : qrbsp_pkg::PAD_BYTE_A;
          olast_d = (padc_q == qrbsp_pkg::padc_t'(1));
          psel_d  = !psel_q;
          padc_d  = padc_q - qrbsp_pkg::padc_t'(1);
          if (padc_q == qrbsp_pkg::padc_t'(1)) begin
            state_d = qrbsp_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = qrbsp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qrbsp_pkg::ST_IDLE;
      rem_q   <= '0;
      held_q  <= '0;
      hcnt_q  <= '0;
      padc_q  <= '0;
      psel_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      held_q  <= held_d;
      hcnt_q  <= hcnt_d;
      padc_q  <= padc_d;
      psel_q  <= psel_d;
      ovld_q  <= ovld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign in_stall_o  = (state_q != qrbsp_pkg::ST_IDLE);
  assign out_valid_o = ovld_q;
  assign out_byte_o  = obyte_q;
  assign last_o      = olast_q;

endmodule
